>>> hdl/swbc_pkg.sv
// ----------------------------------------------------------------------------
// swbc_pkg: shared types and constants of the speed-weighted bin condition
// Field widths, command and status codes, default parameter values.
// ----------------------------------------------------------------------------
package swbc_pkg;

	localparam int MAX_SAMPLES_DEF = 1024;
	localparam int SPEED_BITS_DEF  = 16;

	localparam int SPEED_W = 16;
	localparam int MIN_W   = 10;
	localparam int COND_W  = 16;
	localparam int NZ_W    = 11;
	localparam int CMD_W   = 2;
	localparam int STAT_W  = 2;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 64;
	localparam int M_TUSER_W = 8;
	localparam int M_TDATA_PAD = M_TDATA_W - (3 * COND_W + NZ_W);
	localparam int M_TUSER_PAD = M_TUSER_W - (STAT_W + 1);

	localparam logic [MIN_W-1:0] MIN_SAMPLES_RST = MIN_W'(2);

	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [STAT_W-1:0] STAT_EST  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_ZERO = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FEW  = 2'd2;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> hdl/swbc_div.sv
// ----------------------------------------------------------------------------
// swbc_div: iterative restoring divider
// One quotient bit per cycle through a shared subtractor; the quotient is
// known to fit in Q_W bits, so the top of the dividend preloads the remainder.
// ----------------------------------------------------------------------------
module swbc_div
	import swbc_pkg::*;
#(
	parameter int DEN_W = 26,
	parameter int Q_W   = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [DEN_W+Q_W-1:0]   num,
	input  logic [DEN_W-1:0]       den,
	output logic [Q_W-1:0]         quot,
	output div_stat_t              stat
);

	localparam int CNT_W = $clog2(Q_W);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [Q_W-1:0]   lo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   diff;
	logic             fits;

	assign diff = {rem_q, lo_q[Q_W-1]} - {1'b0, den_q};
	assign fits = ~diff[DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[DEN_W+Q_W-1:Q_W];
			lo_q  <= num[Q_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : {rem_q[DEN_W-2:0], lo_q[Q_W-1]};
			lo_q  <= {lo_q[Q_W-2:0], fits};
		end
	end

	assign quot      = lo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

>>> hdl/speed_weighted_bin_condition_unit.sv
// ----------------------------------------------------------------------------
// speed_weighted_bin_condition_unit: contraharmonic mean per time bin
// Accumulates speed and squared speed per bin, divides at bin close and
// tracks the least and greatest valid result since the last clear.
// ----------------------------------------------------------------------------
// Sample transaction: accept with square, then accumulate.
// Clear or unused command: handled on acceptance; bin close without a divide: S_CLS, then S_FIN.
// Bin close with a divide: S_CLS, S_DIV and S_FIN to the result register, with
//   the one-bit-per-cycle divider in S_DIV; a sample with last passes S_ACC first.
// A waiting result does not block new samples, only the next close.
// arst_n clears accumulators, extremes and min_samples (to 2) at once.
module speed_weighted_bin_condition_unit
	import swbc_pkg::*;
#(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int SPEED_BITS  = SPEED_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [MIN_W-1:0]      cfg_wdata,      // min_samples
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,        // [15:0] speed
	input  logic [CMD_W-1:0]      s_tuser,        // [1:0] cmd
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,        // [15:0] condition, [26:16] nonzero_count,
	                                              // [42:27] lowest, [58:43] highest
	output logic [M_TUSER_W-1:0]  m_tuser         // [1:0] status, [2] extremes_valid
);

	localparam int SW    = (SPEED_BITS < SPEED_W) ? SPEED_BITS : SPEED_W;
	localparam int CW    = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = SW + CW;
	localparam int SQ_W  = 2 * SW + CW;
	localparam int CMP_W = (CW > MIN_W) ? CW : MIN_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ACC  = 3'd1;
	localparam logic [2:0] S_CLS  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]        state_q;
	logic [MIN_W-1:0]  min_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]   sqsum_q;
	logic [CW-1:0]     tot_q;
	logic [CW-1:0]     mov_q;
	logic [COND_W-1:0] low_q;
	logic [COND_W-1:0] high_q;
	logic              mval_q;
	logic              mvalid_q;

	logic [SW-1:0]     spd_q;
	logic [2*SW-1:0]   sq_q;
	logic              last_q;
	logic [SW-1:0]     cond_q;
	logic [STAT_W-1:0] stat_q;
	logic [M_TDATA_W-1:0] odata_q;
	logic [M_TUSER_W-1:0] ouser_q;

	logic [SW-1:0]     spd_in;
	logic              accept;
	logic              fin_go;
	logic              few;
	logic              sum_zero;
	logic              div_start;
	logic              room;
	logic              res_ok;
	logic [COND_W-1:0] cond_w;
	logic [COND_W-1:0] low_nx;
	logic [COND_W-1:0] high_nx;
	logic [SW-1:0]     quot;
	div_stat_t         div_stat;

	assign spd_in    = s_tdata[SW-1:0];
	assign s_tready  = (state_q == S_IDLE) && !div_stat.busy;
	assign accept    = s_tvalid && s_tready;
	assign fin_go    = (state_q == S_FIN) && (!mvalid_q || m_tready);
	assign few       = !(CMP_W'(tot_q) > CMP_W'(min_q));
	assign sum_zero  = (sum_q == '0);
	assign div_start = (state_q == S_CLS) && !few && !sum_zero;
	assign room      = (tot_q < CW'(MAX_SAMPLES));
	assign res_ok    = (stat_q != STAT_FEW);
	assign cond_w    = COND_W'(cond_q);

	always_comb begin
		low_nx  = low_q;
		high_nx = high_q;
		if (res_ok) begin
			if (!mval_q) begin
				low_nx  = cond_w;
				high_nx = cond_w;
			end else begin
				if (cond_w < low_q)  low_nx  = cond_w;
				if (cond_w > high_q) high_nx = cond_w;
			end
		end
	end

	swbc_div #(
		.DEN_W (SUM_W),
		.Q_W   (SW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sqsum_q),
		.den    (sum_q),
		.quot   (quot),
		.stat   (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			min_q    <= MIN_SAMPLES_RST;
			sum_q    <= '0;
			sqsum_q  <= '0;
			tot_q    <= '0;
			mov_q    <= '0;
			low_q    <= '0;
			high_q   <= '0;
			mval_q   <= 1'b0;
			mvalid_q <= 1'b0;
		end else begin
			if (cfg_we) min_q <= cfg_wdata;
			if (fin_go) mvalid_q <= 1'b1;
			else if (m_tready) mvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (s_tuser)
							CMD_ADD:   state_q <= S_ACC;
							CMD_CLOSE: state_q <= S_CLS;
							CMD_CLEAR: begin
								low_q  <= '0;
								high_q <= '0;
								mval_q <= 1'b0;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ACC: begin
					if (room) begin
						sum_q   <= sum_q + SUM_W'(spd_q);
						sqsum_q <= sqsum_q + SQ_W'(sq_q);
						tot_q   <= tot_q + 1'b1;
						if (spd_q != '0) mov_q <= mov_q + 1'b1;
					end
					state_q <= last_q ? S_CLS : S_IDLE;
				end
				S_CLS: state_q <= div_start ? S_DIV : S_FIN;
				S_DIV: if (div_stat.done) state_q <= S_FIN;
				S_FIN: begin
					if (fin_go) begin
						low_q    <= low_nx;
						high_q   <= high_nx;
						mval_q   <= mval_q | res_ok;
						sum_q    <= '0;
						sqsum_q  <= '0;
						tot_q    <= '0;
						mov_q    <= '0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			spd_q  <= spd_in;
			sq_q   <= spd_in * spd_in;
			last_q <= s_tlast;
		end
		if (state_q == S_CLS) begin
			cond_q <= '0;
			stat_q <= few ? STAT_FEW : (sum_zero ? STAT_ZERO : STAT_EST);
		end
		if ((state_q == S_DIV) && div_stat.done) cond_q <= quot;
		if (fin_go) begin
			odata_q <= {{M_TDATA_PAD{1'b0}}, high_nx, low_nx, NZ_W'(mov_q), cond_w};
			ouser_q <= {{M_TUSER_PAD{1'b0}}, mval_q | res_ok, stat_q};
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = odata_q;
	assign m_tuser  = ouser_q;

endmodule

>>> hdl/swbc_chk.sv
// ----------------------------------------------------------------------------
// swbc_chk: port-level checks of the bin condition unit
// Watches the result stream, checks that it holds while stalled and checks status against condition and extremes.
// ----------------------------------------------------------------------------
module swbc_chk
	import swbc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [M_TUSER_W-1:0] m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_no_est_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] != STAT_EST) |-> (m_tdata[15:0] == '0))
		else $error("nonzero condition without estimate");

	a_valid_marks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tuser[1:0] == STAT_EST) || (m_tuser[1:0] == STAT_ZERO))
		|-> m_tuser[2] && (m_tdata[42:27] <= m_tdata[15:0])
		&& (m_tdata[15:0] <= m_tdata[58:43]))
		else $error("valid condition outside extremes");

	a_no_marks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[2] |-> (m_tdata[42:27] == '0) && (m_tdata[58:43] == '0))
		else $error("extremes reported without valid mark");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> (m_tdata[42:27] <= m_tdata[58:43]))
		else $error("lowest above highest");

endmodule

bind speed_weighted_bin_condition_unit swbc_chk u_swbc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

>>> sim/tb_speed_weighted_bin_condition_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_speed_weighted_bin_condition_unit: self-checking bench for the bin unit
// Streams speed samples, bin closes and extreme clears into the unit, predicts
// each bin result (square sum over speed sum, status, nonzero count, extremes)
// and compares every output transaction field by field, under random stalls.
// ----------------------------------------------------------------------------
module tb_speed_weighted_bin_condition_unit;
	import swbc_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int               DRAIN_CYCLES = SPEED_BITS_DEF + 12;

	typedef struct {
		logic [COND_W-1:0] condition;
		logic [STAT_W-1:0] status;
		logic [NZ_W-1:0]   nonzero_count;
		logic [COND_W-1:0] lowest;
		logic [COND_W-1:0] highest;
		logic              extremes_valid;
	} bin_result_t;

	typedef enum int {SPD_ZERO, SPD_LOW, SPD_ANY, SPD_HIGH} speed_mix_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [MIN_W-1:0]     cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [CMD_W-1:0]     s_tuser = CMD_ADD;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	// bin accumulator copy and register copy
	logic [MIN_W-1:0]  min_samples_cfg = MIN_SAMPLES_RST;
	logic [63:0]       acc_speed = '0;
	logic [63:0]       acc_square = '0;
	int unsigned       acc_total = 0;
	int unsigned       acc_moving = 0;
	logic [COND_W-1:0] low_mark = '0;
	logic [COND_W-1:0] high_mark = '0;
	logic              marks_seen = 1'b0;

	bin_result_t pending_conditions[$];
	bit          steady = 1'b0;
	int unsigned mismatch_count = 0;
	int unsigned items_accepted = 0;
	int unsigned bins_estimated = 0;
	int unsigned bins_all_zero = 0;
	int unsigned bins_too_few = 0;

	speed_weighted_bin_condition_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #6 clk = ~clk;

	function automatic bin_result_t close_bin_condition();
		bin_result_t r;
		r.condition = '0;
		if (acc_total > min_samples_cfg) begin
			if (acc_speed != 0) begin
				r.condition = COND_W'(acc_square / acc_speed);
				r.status = STAT_EST;
			end else begin
				r.status = STAT_ZERO;
			end
			if (!marks_seen) begin
				low_mark = r.condition;
				high_mark = r.condition;
				marks_seen = 1'b1;
			end else begin
				if (r.condition < low_mark) low_mark = r.condition;
				if (r.condition > high_mark) high_mark = r.condition;
			end
		end else begin
			r.status = STAT_FEW;
		end
		r.nonzero_count = NZ_W'(acc_moving);
		r.lowest = low_mark;
		r.highest = high_mark;
		r.extremes_valid = marks_seen;
		acc_speed = '0;
		acc_square = '0;
		acc_total = 0;
		acc_moving = 0;
		return r;
	endfunction

	function automatic void update_bin_condition(input logic [CMD_W-1:0] cmd,
			input logic [SPEED_W-1:0] speed, input logic last);
		if (cmd == CMD_ADD) begin
			if (acc_total < MAX_SAMPLES_DEF) begin
				acc_speed += 64'(speed);
				acc_square += 64'(speed) * 64'(speed);
				acc_total++;
				if (speed != 0) acc_moving++;
			end
			if (last) pending_conditions.push_back(close_bin_condition());
		end else if (cmd == CMD_CLOSE) begin
			pending_conditions.push_back(close_bin_condition());
		end else if (cmd == CMD_CLEAR) begin
			low_mark = '0;
			high_mark = '0;
			marks_seen = 1'b0;
		end
	endfunction

	function automatic void check_field(input string label, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
			mismatch_count++;
		end
	endfunction

	function automatic logic [SPEED_W-1:0] pick_speed(input speed_mix_t mix);
		case (mix)
			SPD_ZERO: return '0;
			SPD_LOW:  return SPEED_W'($urandom_range(0, 255));
			SPD_HIGH: return SPEED_W'($urandom_range(16'hFF00, 16'hFFFF));
			default:  return ($urandom_range(0, 9) == 0) ? '0 : SPEED_W'($urandom);
		endcase
	endfunction

	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SPEED_W-1:0] speed,
			input logic last);
		if (!steady && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 12);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= speed;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		update_bin_condition(cmd, speed, last);
		items_accepted++;
	endtask

	task automatic wait_bins_done();
		s_tvalid <= 1'b0;
		while (pending_conditions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_min_samples(input logic [MIN_W-1:0] value);
		wait_bins_done();
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		min_samples_cfg = value;
	endtask

	task automatic test_reset_defaults();
		send_item(CMD_CLOSE, 16'h0000, 1'b1);
		send_item(CMD_ADD, 16'h1234, 1'b0);
		send_item(CMD_ADD, 16'h0100, 1'b1);
		send_item(CMD_ADD, 16'h0000, 1'b0);
		send_item(CMD_ADD, 16'h0000, 1'b0);
		send_item(CMD_ADD, 16'h0000, 1'b1);
		send_item(CMD_ADD, 16'hFFFF, 1'b0);
		send_item(CMD_ADD, 16'hFFFF, 1'b0);
		send_item(CMD_ADD, 16'hFFFF, 1'b1);
		send_item(CMD_UNUSED, 16'hFFFF, 1'b1);
		send_item(CMD_CLEAR, 16'hAAAA, 1'b1);
		send_item(CMD_ADD, 16'h0001, 1'b0);
		send_item(CMD_ADD, 16'h0002, 1'b0);
		send_item(CMD_ADD, 16'h0000, 1'b0);
		send_item(CMD_CLOSE, 16'h5555, 1'b0);
		send_item(CMD_ADD, 16'h5555, 1'b0);
		send_item(CMD_ADD, 16'hAAAA, 1'b0);
		send_item(CMD_ADD, 16'h8000, 1'b1);
	endtask

	task automatic test_min_samples_limits();
		set_min_samples(MIN_W'(0));
		send_item(CMD_ADD, 16'h00FF, 1'b1);
		send_item(CMD_CLOSE, 16'h0000, 1'b0);
		set_min_samples({MIN_W{1'b1}});
		repeat (3) send_item(CMD_ADD, SPEED_W'($urandom), 1'b0);
		send_item(CMD_ADD, 16'h7FFF, 1'b1);
	endtask

	task automatic test_count_saturation();
		set_min_samples({MIN_W{1'b1}});
		for (int i = 0; i < MAX_SAMPLES_DEF + 6; i++)
			send_item(CMD_ADD, pick_speed((i < MAX_SAMPLES_DEF / 2) ? SPD_ANY : SPD_HIGH),
				i == MAX_SAMPLES_DEF + 5);
	endtask

	task automatic test_random_bins(input int unsigned items, input logic [MIN_W-1:0] min_value,
			input bit no_idle);
		int unsigned sent;
		int unsigned len;
		int unsigned pick;
		bit          close_by_cmd;
		speed_mix_t  mix;
		sent = 0;
		set_min_samples(min_value);
		steady = no_idle;
		while (sent < items) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				send_item(CMD_CLEAR, SPEED_W'($urandom), 1'($urandom));
				sent++;
			end else if (pick < 7) begin
				send_item(CMD_UNUSED, SPEED_W'($urandom), 1'($urandom));
			end else if (pick < 11) begin
				send_item(CMD_CLOSE, SPEED_W'($urandom), 1'($urandom));
				sent++;
			end else begin
				len = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 16);
				close_by_cmd = ($urandom_range(4) == 0);
				mix = speed_mix_t'($urandom_range(0, 3));
				for (int i = 0; i < len; i++)
					send_item(CMD_ADD, pick_speed(mix), !close_by_cmd && i == len - 1);
				sent += len;
				// leave a few bins open so they merge into the next one
				if (close_by_cmd && $urandom_range(9) != 0) begin
					send_item(CMD_CLOSE, SPEED_W'($urandom), 1'($urandom));
					sent++;
				end
			end
		end
		steady = 1'b0;
	endtask

	always @(posedge clk) begin : result_monitor
		bin_result_t seen;
		bin_result_t want;
		if (arst_n) begin
			m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 12);
			if (m_tvalid && m_tready) begin
				seen.condition = m_tdata[15:0];
				seen.nonzero_count = m_tdata[26:16];
				seen.lowest = m_tdata[42:27];
				seen.highest = m_tdata[58:43];
				seen.status = m_tuser[1:0];
				seen.extremes_valid = m_tuser[2];
				case (seen.status)
					STAT_EST:  bins_estimated++;
					STAT_ZERO: bins_all_zero++;
					default:   bins_too_few++;
				endcase
				if (pending_conditions.size() == 0) begin
					$display("%0t ns: result with none expected, actual condition %0d status %0d",
						$time, seen.condition, seen.status);
					mismatch_count++;
				end else begin
					want = pending_conditions.pop_front();
					check_field("condition", want.condition, seen.condition);
					check_field("status", want.status, seen.status);
					check_field("nonzero_count", want.nonzero_count, seen.nonzero_count);
					check_field("lowest", want.lowest, seen.lowest);
					check_field("highest", want.highest, seen.highest);
					check_field("extremes_valid", want.extremes_valid, seen.extremes_valid);
				end
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_min_samples_limits();
		test_count_saturation();
		test_random_bins(80, MIN_W'(0), 1'b0);
		test_random_bins(80, MIN_W'(3), 1'b0);
		test_random_bins(80, MIN_W'($urandom_range(0, 12)), 1'b1);
		test_random_bins(80, MIN_SAMPLES_RST, 1'b0);
		wait_bins_done();
		if (pending_conditions.size() != 0) mismatch_count++;
		$display("Accepted %0d input transactions; bins closed: %0d estimates, %0d all zero, %0d too few",
			items_accepted, bins_estimated, bins_all_zero, bins_too_few);
		$display("min_samples ran at 0, 2, 3, 1023 and a random value; one bin hit the count limit");
		if (mismatch_count == 0)
			$display("speed_weighted_bin_condition_unit test passed");
		else
			$display("speed_weighted_bin_condition_unit test failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timeout with %0d results outstanding", pending_conditions.size());
		$display("speed_weighted_bin_condition_unit test failed");
		$finish;
	end

endmodule
